/* rtl/ftwr_pkg.sv */
package ftwr_pkg;

  localparam int MAX_LOG2_SIZE = 12;
  localparam int SAMPLE_WIDTH  = 18;
  localparam int PHASE_WIDTH   = 24;

  localparam int IDX_W     = 12;
  localparam int LSZ_W     = 4;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_W = 30;
  localparam int UNIT_W = FRAC_W + 1;

  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] samp_t;

  localparam unit_t Q_ONE = unit_t'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_LOG2_SIZE  = 2'd1,
    CFG_LOG2_PARTS = 2'd2,
    CFG_PART_INDEX = 2'd3
  } cfg_idx_t;

  localparam logic             RST_DIRECTION  = 1'b0;
  localparam logic [LSZ_W-1:0] RST_LOG2_SIZE  = 4'd7;
  localparam logic [LSZ_W-1:0] RST_LOG2_PARTS = 4'd2;
  localparam logic [IDX_W-1:0] RST_PART_INDEX = '0;

endpackage

/* rtl/ftwr_sincos.sv */
module ftwr_sincos (
  input  logic            clk,
  input  logic            en,
  input  ftwr_pkg::frac_t x_i,
  output ftwr_pkg::unit_t cos_o,
  output ftwr_pkg::frac_t sin_o
);
  import ftwr_pkg::*;

  // floor(v / d) = (v * ceil(2^S / d)) >> S, exact for v < 2^30 with S = 30 + ceil(log2 d)
  localparam int SH56 = 36;
  localparam int SH72 = 37;
  localparam int SH30 = 35;
  localparam int SH42 = 36;
  localparam int SH12 = 34;
  localparam int SH20 = 35;
  localparam int SH6  = 33;
  localparam logic [31:0] RCP56 = 32'(((64'd1 << SH56) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP72 = 32'(((64'd1 << SH72) + 64'd71) / 64'd72);
  localparam logic [31:0] RCP30 = 32'(((64'd1 << SH30) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP42 = 32'(((64'd1 << SH42) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP12 = 32'(((64'd1 << SH12) + 64'd11) / 64'd12);
  localparam logic [31:0] RCP20 = 32'(((64'd1 << SH20) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP6  = 32'(((64'd1 << SH6) + 64'd5) / 64'd6);

  function automatic unit_t one_minus_div(frac_t v, logic [31:0] rcp, int sh);
    logic [FRAC_W+31:0] p;
    p = (FRAC_W+32)'(v) * (FRAC_W+32)'(rcp);
    return Q_ONE - unit_t'(p >> sh);
  endfunction

  function automatic frac_t mul_q(frac_t a, unit_t b);
    logic [2*FRAC_W:0] p;
    p = (2*FRAC_W+1)'(a) * (2*FRAC_W+1)'(b);
    return frac_t'(p >> FRAC_W);
  endfunction

  frac_t x_dly_r  [0:7];
  frac_t x2_r;
  frac_t x2_dly_r [0:4];
  unit_t ct_r     [0:2];
  unit_t st_r     [0:3];
  frac_t cp_r     [0:2];
  frac_t sp_r     [0:2];
  unit_t cos8_r;
  unit_t cos_r;
  frac_t sin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r        <= mul_q(x_i, unit_t'(x_i));
      x_dly_r[0]  <= x_i;
      for (int i = 1; i < 8; i++) begin
        x_dly_r[i] <= x_dly_r[i-1];
      end
      x2_dly_r[0] <= x2_r;
      for (int i = 1; i < 5; i++) begin
        x2_dly_r[i] <= x2_dly_r[i-1];
      end

      ct_r[0] <= one_minus_div(x2_r, RCP56, SH56);
      st_r[0] <= one_minus_div(x2_r, RCP72, SH72);
      cp_r[0] <= mul_q(x2_dly_r[0], ct_r[0]);
      sp_r[0] <= mul_q(x2_dly_r[0], st_r[0]);

      ct_r[1] <= one_minus_div(cp_r[0], RCP30, SH30);
      st_r[1] <= one_minus_div(sp_r[0], RCP42, SH42);
      cp_r[1] <= mul_q(x2_dly_r[2], ct_r[1]);
      sp_r[1] <= mul_q(x2_dly_r[2], st_r[1]);

      ct_r[2] <= one_minus_div(cp_r[1], RCP12, SH12);
      st_r[2] <= one_minus_div(sp_r[1], RCP20, SH20);
      cp_r[2] <= mul_q(x2_dly_r[4], ct_r[2]);
      sp_r[2] <= mul_q(x2_dly_r[4], st_r[2]);

      cos8_r  <= Q_ONE - unit_t'(cp_r[2] >> 1);
      st_r[3] <= one_minus_div(sp_r[2], RCP6, SH6);

      cos_r <= cos8_r;
      sin_r <= mul_q(x_dly_r[7], st_r[3]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

/* rtl/four_step_fft_twiddle_rotator_core.sv */
// Throughput: one item per cycle while out_stall stays low; a stalled result moves into a
// one-entry skid register, and in_stall holds input and pipeline until the skid empties.
// Reset (rst_n low, synchronous): pipeline valid bits and skid cleared,
// registers back to direction 0, log2_size 7, log2_parts 2, part_index 0.
module four_step_fft_twiddle_rotator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ftwr_pkg::IDX_W-1:0]      in_local_row,
  input  logic [ftwr_pkg::IDX_W-1:0]      in_column,
  input  ftwr_pkg::samp_t                 in_sample_re,
  input  ftwr_pkg::samp_t                 in_sample_im,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ftwr_pkg::samp_t                 out_rotated_re,
  output ftwr_pkg::samp_t                 out_rotated_im,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftwr_pkg::CFG_W-1:0]      cfg_data
);
  import ftwr_pkg::*;

  localparam int NSTAGE = 16;
  localparam int LAST   = NSTAGE - 1;
  localparam int SC_LAT = 9;
  localparam int SC_OUT = 4 + SC_LAT;
  localparam int PROD_W = 2 * MAX_LOG2_SIZE;
  localparam int WIDE_W = PROD_W + PHASE_WIDTH;
  localparam int MAG_W  = PHASE_WIDTH - 2;
  localparam int XK_W   = MAG_W + 31;
  localparam int ROT_W  = SAMPLE_WIDTH + 1;
  localparam int PRD_W  = UNIT_W + 1 + ROT_W;

  typedef logic [PHASE_WIDTH-1:0]  ang_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic signed [PRD_W:0]   sum_t;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam ang_t ANG_EIGHTH = ang_t'(1) << (PHASE_WIDTH - 3);
  localparam mag_t MAG_HALF   = mag_t'(1) << (PHASE_WIDTH - 3);
  localparam sum_t RND_HALF   = sum_t'(1) << (FRAC_W - 1);
  localparam sum_t SAT_HI     = (sum_t'(1) << (SAMPLE_WIDTH - 1)) - sum_t'(1);
  localparam sum_t SAT_LO     = -(sum_t'(1) << (SAMPLE_WIDTH - 1));

  function automatic samp_t round_sat(sum_t v);
    sum_t t;
    t = (v + RND_HALF) >>> FRAC_W;
    if (t > SAT_HI) begin
      return samp_t'(SAT_HI);
    end
    if (t < SAT_LO) begin
      return samp_t'(SAT_LO);
    end
    return samp_t'(t);
  endfunction

  // configuration
  logic             dir_r;
  logic [LSZ_W-1:0] log2_size_r;
  logic [LSZ_W-1:0] log2_parts_r;
  logic [IDX_W-1:0] part_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= RST_DIRECTION;
      log2_size_r  <= RST_LOG2_SIZE;
      log2_parts_r <= RST_LOG2_PARTS;
      part_index_r <= RST_PART_INDEX;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRECTION:  dir_r        <= cfg_data[0];
        CFG_LOG2_SIZE:  log2_size_r  <= cfg_data[LSZ_W-1:0];
        CFG_LOG2_PARTS: log2_parts_r <= cfg_data[LSZ_W-1:0];
        CFG_PART_INDEX: part_index_r <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic [LSZ_W-1:0] lsz;
  logic [LSZ_W-1:0] lpt;
  logic [LSZ_W-1:0] grow_sh;
  logic [LSZ_W:0]   dbl_lsz;

  assign lsz     = (log2_size_r > LSZ_W'(MAX_LOG2_SIZE)) ? LSZ_W'(MAX_LOG2_SIZE) : log2_size_r;
  assign lpt     = (log2_parts_r > lsz) ? lsz : log2_parts_r;
  assign grow_sh = lsz - lpt;
  assign dbl_lsz = {lsz, 1'b0};

  // pipeline control
  logic [NSTAGE-1:0] vld_r;
  logic              en;
  logic              skid_vld_r;
  logic              skid_vld_nxt;
  samp_t             skid_re_r;
  samp_t             skid_im_r;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  // stage 1: global row
  logic [PROD_W-1:0] grow1_r;
  logic [IDX_W-1:0]  col1_r;
  samp_t             re1_r, im1_r;

  // stage 2: phase
  logic [PROD_W-1:0] phase2_r;
  samp_t             re2_r, im2_r;
  logic [PROD_W+IDX_W-1:0] prod_full;
  logic [PROD_W-1:0]       phase_mask;

  // stage 3: angle in turns
  ang_t              ang3_r;
  samp_t             re3_r, im3_r;
  logic [WIDE_W-1:0] ang_wide;
  ang_t              ang_pos;

  // stage 4: quadrant and residual
  logic [1:0] q4_r;
  logic       neg4_r;
  mag_t       mag4_r;
  samp_t      re4_r, im4_r;
  ang_t       ang_b;

  // stage 5: radians and quadrant rotation
  frac_t           x5_r;
  rot_t            rq_re5_r, rq_im5_r;
  logic            neg5_r;
  logic [XK_W-1:0] xk;
  rot_t            rq_re, rq_im, re4_x, im4_x;

  always_comb begin
    prod_full  = (PROD_W+IDX_W)'(grow1_r) * (PROD_W+IDX_W)'(col1_r);
    phase_mask = ~({PROD_W{1'b1}} << dbl_lsz);
    ang_wide   = {phase2_r, PHASE_WIDTH'(0)} >> dbl_lsz;
    ang_pos    = ang_wide[PHASE_WIDTH-1:0];
    ang_b      = ang3_r + ANG_EIGHTH;
    xk         = XK_W'(mag4_r) * XK_W'(HALF_PI_Q30);
    re4_x      = ROT_W'(re4_r);
    im4_x      = ROT_W'(im4_r);
    case (q4_r)
      2'd1: begin
        rq_re = -im4_x;
        rq_im = re4_x;
      end
      2'd2: begin
        rq_re = -re4_x;
        rq_im = -im4_x;
      end
      2'd3: begin
        rq_re = im4_x;
        rq_im = -re4_x;
      end
      default: begin
        rq_re = re4_x;
        rq_im = im4_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grow1_r <= PROD_W'(in_local_row) + (PROD_W'(part_index_r) << grow_sh);
      col1_r  <= in_column;
      re1_r   <= in_sample_re;
      im1_r   <= in_sample_im;

      phase2_r <= prod_full[PROD_W-1:0] & phase_mask;
      re2_r    <= re1_r;
      im2_r    <= im1_r;

      ang3_r <= dir_r ? ang_pos : -ang_pos;
      re3_r  <= re2_r;
      im3_r  <= im2_r;

      q4_r   <= ang_b[PHASE_WIDTH-1 -: 2];
      neg4_r <= !ang_b[PHASE_WIDTH-3];
      mag4_r <= ang_b[PHASE_WIDTH-3] ? {1'b0, ang_b[PHASE_WIDTH-4:0]}
                                     : MAG_HALF - ang_b[PHASE_WIDTH-3:0];
      re4_r  <= re3_r;
      im4_r  <= im3_r;

      x5_r     <= frac_t'(xk >> MAG_W);
      rq_re5_r <= rq_re;
      rq_im5_r <= rq_im;
      neg5_r   <= neg4_r;
    end
  end

  // stages 6 to 14: cos and sin
  unit_t cos_w;
  frac_t sin_w;

  ftwr_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .x_i   (x5_r),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  rot_t rq_re_dly_r [0:SC_LAT-1];
  rot_t rq_im_dly_r [0:SC_LAT-1];
  logic neg_dly_r   [0:SC_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rq_re_dly_r[0] <= rq_re5_r;
      rq_im_dly_r[0] <= rq_im5_r;
      neg_dly_r[0]   <= neg5_r;
      for (int i = 1; i < SC_LAT; i++) begin
        rq_re_dly_r[i] <= rq_re_dly_r[i-1];
        rq_im_dly_r[i] <= rq_im_dly_r[i-1];
        neg_dly_r[i]   <= neg_dly_r[i-1];
      end
    end
  end

  // stage 15: complex products
  logic signed [UNIT_W:0] cs, ss;
  prd_t prr15_r, pii15_r, pri15_r, pir15_r;

  always_comb begin
    cs = $signed({1'b0, cos_w});
    ss = neg_dly_r[SC_LAT-1] ? -$signed({2'b00, sin_w}) : $signed({2'b00, sin_w});
  end

  // stage 16: round and saturate
  samp_t res_re_r, res_im_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prr15_r <= cs * rq_re_dly_r[SC_LAT-1];
      pii15_r <= ss * rq_im_dly_r[SC_LAT-1];
      pri15_r <= ss * rq_re_dly_r[SC_LAT-1];
      pir15_r <= cs * rq_im_dly_r[SC_LAT-1];

      res_re_r <= round_sat(sum_t'(prr15_r) - sum_t'(pii15_r));
      res_im_r <= round_sat(sum_t'(pri15_r) + sum_t'(pir15_r));
    end
  end

  // output skid
  assign skid_vld_nxt = skid_vld_r ? out_stall : (vld_r[LAST] && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_re_r <= res_re_r;
      skid_im_r <= res_im_r;
    end
  end

  assign out_valid      = skid_vld_r || vld_r[LAST];
  assign out_rotated_re = skid_vld_r ? skid_re_r : res_re_r;
  assign out_rotated_im = skid_vld_r ? skid_im_r : res_im_r;

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_stall |=> skid_vld_r && $stable(skid_re_r) && $stable(skid_im_r))
    else $error("skid entry lost or changed while output stalled");

  a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && out_stall && !skid_vld_r |=>
      skid_vld_r && skid_re_r == $past(res_re_r) && skid_im_r == $past(res_im_r))
    else $error("stalled result not captured by skid");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(vld_r))
    else $error("pipeline advanced while skid full");

  a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SC_OUT] |-> cos_w <= Q_ONE)
    else $error("cosine above one");

endmodule
